// ===== src/scs_pkg.sv =====
// Shared types, constants and register codes for the sensor conditioner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package scs_pkg;

  localparam int unsigned SENSORS_DEF = 8;
  // Calibration build options.
  localparam bit EXACT_SENSE = 1'b0;
  localparam bit SENSE_NEEDS_PEDAL = 1'b0;

  localparam int unsigned CFG_W = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned QDEPTH = 2;

  localparam logic [9:0] SMP_MAX = 10'd1023;
  localparam logic [9:0] MIN_RST = 10'd64;
  localparam logic [9:0] MAX_RST = 10'd880;
  localparam logic [7:0] FAC_RST = 8'd4;
  localparam logic [7:0] EXACT_DIV = 8'd127;
  localparam logic [55:0] SCALE_TO_RST = 56'hFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_RELEASE  = 3'd1,
    REG_INVERT   = 3'd2,
    REG_PEDAL    = 3'd3,
    REG_AUTOSENS = 3'd4,
    REG_SLOWDOWN = 3'd5,
    REG_FROM     = 3'd6,
    REG_TO       = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_SENT  = 2'd0,
    ST_ABORT = 2'd1,
    ST_BELOW = 2'd2,
    ST_CAL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_MIN = 2'd1,
    MODE_MAX = 2'd2,
    MODE_RECALC = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0]  enable;
    logic [7:0]  rel_mask;
    logic [7:0]  invert;
    logic [7:0]  pedal_gate;
    logic [15:0] autosense;
    logic [63:0] slowdown;
    logic [55:0] scale_from;
    logic [55:0] scale_to;
  } cfg_t;

  typedef struct packed {
    logic [2:0] ch;
    logic [9:0] smp;
    logic       pedal;
    logic       drop;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

endpackage

// ===== src/sensor_calibrate_scale_conditioner.sv =====
// Top level of the sensor calibrate / scale conditioner: configuration
// registers and the front, queue, divider and back end. Depends on scs_pkg.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+---------------------
//   input   | in_sensor_index, in_sample, in_pedal_up | in_valid / in_ready
//   result  | out_status, out_value                   | out_valid / out_ready
//   config  | cfg_index, cfg_wdata                    | cfg_we, no wait
//
// The back end works one item at a time, in steps: pop, evaluate, scale
// multiply, range check, result transfer; items that end at evaluation skip
// the scale multiply and range check. No item is popped while a result
// waits. A divide factor other than 0, 1, 2, 4, 8 or 16 adds a pass through
// the serial 16-bit divider before the scale multiply.
// Reset is synchronous; it restores the register defaults and the per-sensor
// tables at once. While a result stalls, the two-entry queue fills up.
`timescale 1ns / 1ps
module sensor_calibrate_scale_conditioner import scs_pkg::*; #(
  parameter int unsigned SENSORS = SENSORS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_sensor_index,
  input  logic [9:0]           in_sample,
  input  logic                 in_pedal_up,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [6:0]           out_value,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t        cfg_r;
  logic        push_valid, push_ready, q_valid, q_pop;
  item_t       push_item, q_item;
  div_req_t    div_req;
  logic        div_done;
  logic [15:0] div_quot;

  // Register write: take the low bits of the data for narrow registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable       <= 8'd15;
      cfg_r.rel_mask     <= 8'd15;
      cfg_r.invert       <= '0;
      cfg_r.pedal_gate   <= '0;
      cfg_r.autosense    <= '0;
      cfg_r.slowdown     <= '0;
      cfg_r.scale_from   <= '0;
      cfg_r.scale_to     <= SCALE_TO_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ENABLE:   cfg_r.enable       <= cfg_wdata[7:0];
        REG_RELEASE:  cfg_r.rel_mask     <= cfg_wdata[7:0];
        REG_INVERT:   cfg_r.invert       <= cfg_wdata[7:0];
        REG_PEDAL:    cfg_r.pedal_gate   <= cfg_wdata[7:0];
        REG_AUTOSENS: cfg_r.autosense    <= cfg_wdata[15:0];
        REG_SLOWDOWN: cfg_r.slowdown     <= cfg_wdata;
        REG_FROM:     cfg_r.scale_from   <= cfg_wdata[55:0];
        REG_TO:       cfg_r.scale_to     <= cfg_wdata[55:0];
        default:      cfg_r.enable       <= cfg_r.enable;
      endcase
    end
  end

  // Classify each transfer: drop disabled, out-of-range or pedal-gated ones.
  scs_front #(.SENSORS(SENSORS)) u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sensor_index (in_sensor_index),
    .in_sample       (in_sample),
    .in_pedal_up     (in_pedal_up),
    .cfg             (cfg_r),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_item       (push_item)
  );

  // Decouple front and back so either side can stall.
  scs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // Divider for divide factors other than 0, 1, 2, 4, 8 and 16.
  scs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Carry out calibration or conditioning and hold the result register.
  scs_back #(.SENSORS(SENSORS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_done   (div_done),
    .div_quot   (div_quot),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_value  (out_value)
  );

endmodule

// ===== src/scs_front.sv =====
// Front end: accepts input transfers and classifies them as drop or process.
// Depends on scs_pkg.
`timescale 1ns / 1ps
module scs_front import scs_pkg::*; #(
  parameter int unsigned SENSORS = SENSORS_DEF
) (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_sensor_index,
  input  logic [9:0] in_sample,
  input  logic       in_pedal_up,
  input  cfg_t       cfg,
  output logic       push_valid,
  input  logic       push_ready,
  output item_t      push_item
);

  logic out_of_range;

  assign out_of_range = {1'b0, in_sensor_index} >= 4'(SENSORS);

  always_comb begin
    push_item.ch    = in_sensor_index;
    push_item.smp   = in_sample;
    push_item.pedal = in_pedal_up;
    push_item.drop  = out_of_range || !cfg.enable[in_sensor_index] ||
                      (cfg.pedal_gate[in_sensor_index] && in_pedal_up);
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

// ===== src/scs_fifo.sv =====
// Short item queue between front and back end.
// Depends on scs_pkg.
`timescale 1ns / 1ps
module scs_fifo import scs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop,
  output item_t pop_item
);

  localparam int unsigned PTR_W = $clog2(QDEPTH);

  item_t             mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]    cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = cnt_r != (PTR_W+1)'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/scs_div.sv =====
// Restoring serial divider, one quotient bit per cycle (16 bits by 8 bits).
// Depends on scs_pkg.
`timescale 1ns / 1ps
module scs_div import scs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        done,
  output logic [15:0] quot
);

  logic [15:0] q_r;
  logic [7:0]  rem_r;
  logic [7:0]  d_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [8:0]  trial;
  logic        fits;

  assign trial = {rem_r, q_r[15]};
  assign fits  = trial >= {1'b0, d_r};
  assign done  = done_r;
  assign quot  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd16;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      d_r   <= req.divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[14:0], fits};
      rem_r <= fits ? 8'(trial - {1'b0, d_r}) : trial[7:0];
    end
  end

endmodule

// ===== src/scs_back.sv =====
// Back end: per-sensor state, calibration, conditioning, scaling, result register.
// Depends on scs_pkg; drives the scs_div unit.
`timescale 1ns / 1ps
module scs_back import scs_pkg::*; #(
  parameter int unsigned SENSORS = SENSORS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output div_req_t    div_req,
  input  logic        div_done,
  input  logic [15:0] div_quot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [6:0]  out_value
);

  localparam int unsigned CH_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_EVAL  = 5'b00010,
    B_DIV   = 5'b00100,
    B_SCALE = 5'b01000,
    B_CHECK = 5'b10000
  } bstate_t;

  bstate_t     state_r, state_nxt;
  item_t       item_r, item_nxt;
  logic [7:0]  v8_r, v8_nxt;
  logic [14:0] prod_r, prod_nxt;
  logic [9:0]  min_r [SENSORS], min_nxt [SENSORS];
  logic [9:0]  max_r [SENSORS], max_nxt [SENSORS];
  logic [7:0]  fac_r [SENSORS], fac_nxt [SENSORS];
  logic [7:0]  last_r [SENSORS], last_nxt [SENSORS];
  logic [7:0]  cnt_r [SENSORS], cnt_nxt [SENSORS];
  logic        ov_r, ov_nxt;
  status_t     ost_r, ost_nxt;
  logic [6:0]  oval_r, oval_nxt;

  logic [CH_W-1:0] idx;
  logic [2:0]  ch;
  logic [7:0]  slow, cnt_inc;
  mode_t       mode;
  logic [6:0]  from, to;
  logic [9:0]  cur_min, cur_max, new_min, new_max, rng, smp_c;
  logic [15:0] v16;
  logic [7:0]  fac, vn, pow_fac, exact_fac;

  assign ch      = item_r.ch;
  assign idx     = ch[CH_W-1:0];
  assign slow    = cfg.slowdown[{ch, 3'b000} +: 8];
  assign mode    = mode_t'(cfg.autosense[{ch, 1'b0} +: 2]);
  assign from    = cfg.scale_from[int'(ch) * 7 +: 7];
  assign to      = cfg.scale_to[int'(ch) * 7 +: 7];
  assign cur_min = min_r[idx];
  assign cur_max = max_r[idx];
  assign fac     = fac_r[idx];
  assign cnt_inc = cnt_r[idx] + 8'd1;
  assign new_min = (mode == MODE_MIN) ? item_r.smp : cur_min;
  assign new_max = (mode == MODE_MAX) ? item_r.smp : cur_max;
  assign rng     = new_max - new_min;
  assign smp_c   = cfg.invert[ch] ? SMP_MAX - item_r.smp : item_r.smp;
  assign v16     = {6'b0, smp_c} - {6'b0, cur_min};
  assign vn      = 8'({1'b0, from}) + prod_r[14:7];

  always_comb begin
    if (rng < 10'd128) begin
      pow_fac = 8'd1;
    end else if (rng < 10'd256) begin
      pow_fac = 8'd2;
    end else if (rng < 10'd512) begin
      pow_fac = 8'd4;
    end else begin
      pow_fac = 8'd8;
    end
  end

  // Range / 127 by counting the multiples it reaches; the range stays below 1024.
  always_comb begin
    exact_fac = 8'd0;
    for (int k = 1; k <= 8; k++) begin
      if ({1'b0, rng} >= 11'(k * int'(EXACT_DIV))) begin
        exact_fac = exact_fac + 8'd1;
      end
    end
    if (exact_fac == 8'd0) begin
      exact_fac = 8'd1;
    end
  end

  assign q_pop      = (state_r == B_IDLE) && q_valid && !ov_r;
  assign out_valid  = ov_r;
  assign out_status = ost_r;
  assign out_value  = oval_r;

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    v8_nxt    = v8_r;
    prod_nxt  = prod_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    fac_nxt   = fac_r;
    last_nxt  = last_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_ready;
    ost_nxt   = ost_r;
    oval_nxt  = oval_r;
    div_req.start    = 1'b0;
    div_req.dividend = v16;
    div_req.divisor  = fac;

    case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          item_nxt  = q_item;
          state_nxt = B_EVAL;
        end
      end
      B_EVAL: begin
        state_nxt = B_IDLE;
        ov_nxt    = 1'b1;
        ost_nxt   = ST_ABORT;
        oval_nxt  = '0;
        if (!item_r.drop) begin
          if (slow != 8'd0) begin
            cnt_nxt[idx] = (cnt_inc >= slow) ? 8'd0 : cnt_inc;
          end
          if (slow != 8'd0 && cnt_inc < slow) begin
            ost_nxt = ST_ABORT;
          end else if (mode != MODE_OFF) begin
            ost_nxt = ST_CAL;
            if (!(SENSE_NEEDS_PEDAL && item_r.pedal)) begin
              min_nxt[idx] = new_min;
              max_nxt[idx] = new_max;
              if (new_min > new_max) begin
                min_nxt[idx] = new_max;
                fac_nxt[idx] = 8'd1;
              end else if (EXACT_SENSE) begin
                fac_nxt[idx] = exact_fac;
              end else begin
                fac_nxt[idx] = pow_fac;
              end
            end
          end else if (item_r.smp < cur_min) begin
            if (cfg.rel_mask[ch] && last_r[idx] != 8'd0) begin
              last_nxt[idx] = 8'd0;
              ost_nxt = ST_SENT;
            end else begin
              ost_nxt = ST_BELOW;
            end
          end else if (item_r.smp > cur_max) begin
            ost_nxt = ST_ABORT;
          end else begin
            ov_nxt    = 1'b0;
            state_nxt = B_SCALE;
            case (fac)
              8'd0, 8'd1: v8_nxt = v16[7:0];
              8'd2:       v8_nxt = v16[8:1];
              8'd4:       v8_nxt = v16[9:2];
              8'd8:       v8_nxt = v16[10:3];
              8'd16:      v8_nxt = v16[11:4];
              default: begin
                div_req.start = 1'b1;
                state_nxt     = B_DIV;
              end
            endcase
          end
        end
      end
      B_DIV: begin
        if (div_done) begin
          v8_nxt    = div_quot[7:0];
          state_nxt = B_SCALE;
        end
      end
      B_SCALE: begin
        if (to < from) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ST_ABORT;
          oval_nxt  = '0;
          state_nxt = B_IDLE;
        end else begin
          prod_nxt  = 15'(v8_r * (to - from));
          state_nxt = B_CHECK;
        end
      end
      B_CHECK: begin
        ov_nxt    = 1'b1;
        ost_nxt   = ST_ABORT;
        oval_nxt  = '0;
        state_nxt = B_IDLE;
        if (vn >= {1'b0, from} && vn <= {1'b0, to} && vn != last_r[idx]) begin
          last_nxt[idx] = vn;
          ost_nxt  = ST_SENT;
          oval_nxt = vn[6:0];
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
      for (int i = 0; i < int'(SENSORS); i++) begin
        min_r[i]  <= MIN_RST;
        max_r[i]  <= MAX_RST;
        fac_r[i]  <= FAC_RST;
        last_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      fac_r   <= fac_nxt;
      last_r  <= last_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    v8_r   <= v8_nxt;
    prod_r <= prod_nxt;
    ost_r  <= ost_nxt;
    oval_r <= oval_nxt;
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the sensor calibrate / scale conditioner: random and
// directed samples through a valid/ready driver, results checked per transfer.
// Depends on scs_pkg and sensor_calibrate_scale_conditioner.
`timescale 1ns / 1ps
module tb_top;
  import scs_pkg::*;

  typedef struct packed {
    logic [2:0] ch;
    logic [9:0] smp;
    logic       pedal;
  } sample_t;

  typedef struct packed {
    status_t    status;
    logic [6:0] value;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_sensor_index = '0;
  logic [9:0] in_sample = '0;
  logic in_pedal_up = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [6:0] out_value;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  sensor_calibrate_scale_conditioner DUT (.*);

  always #4 clk = ~clk;

  // Shadow of the block: registers and per-sensor tables.
  cfg_t       shadow_cfg;
  logic [9:0] lo_tab [8];
  logic [9:0] hi_tab [8];
  logic [7:0] fac_tab [8];
  logic [7:0] sent_tab [8];
  logic [7:0] skip_cnt [8];

  sample_t  pending_samples [$];
  verdict_t expected_verdicts [$];
  int  errors = 0;
  bit  stim_done = 1'b0;
  bit  hold_off = 1'b0;   // monitor holds out_ready low while set
  bit  gate_send = 1'b0;  // driver starts no new offer while set

  task automatic shadow_reset();
    shadow_cfg = '{enable: 8'd15, rel_mask: 8'd15, invert: 8'd0, pedal_gate: 8'd0,
                   autosense: 16'd0, slowdown: 64'd0, scale_from: 56'd0,
                   scale_to: SCALE_TO_RST};
    for (int i = 0; i < 8; i++) begin
      lo_tab[i] = MIN_RST; hi_tab[i] = MAX_RST; fac_tab[i] = FAC_RST;
      sent_tab[i] = '0; skip_cnt[i] = '0;
    end
  endtask

  // Compute the verdict for one sample and advance the shadow tables.
  function automatic verdict_t condition_sample(sample_t s);
    verdict_t r;
    int c;
    logic [7:0] n;
    mode_t m;
    logic [9:0] x;
    logic [15:0] d16;
    logic [7:0] d8, fr, tt;
    logic [10:0] rng;
    logic [15:0] prod;
    logic [7:0] y;
    c = s.ch;
    r.status = ST_ABORT; r.value = '0;
    if (c >= SENSORS_DEF || !shadow_cfg.enable[c]) return r;
    if (shadow_cfg.pedal_gate[c] && s.pedal) return r;
    n = shadow_cfg.slowdown[8*c +: 8];
    if (n != 0) begin
      skip_cnt[c] = skip_cnt[c] + 8'd1;
      if (skip_cnt[c] >= n) skip_cnt[c] = '0;
      else return r;
    end
    m = mode_t'(shadow_cfg.autosense[2*c +: 2]);
    if (m != MODE_OFF) begin
      r.status = ST_CAL;
      if (SENSE_NEEDS_PEDAL && s.pedal) return r;
      fac_tab[c] = 8'd1;
      if (m == MODE_MIN) lo_tab[c] = s.smp;
      else if (m == MODE_MAX) hi_tab[c] = s.smp;
      if (lo_tab[c] > hi_tab[c]) begin
        lo_tab[c] = hi_tab[c];
        return r;
      end
      rng = hi_tab[c] - lo_tab[c];
      if (EXACT_SENSE) begin
        fac_tab[c] = 8'(rng / 127);
        if (fac_tab[c] == 0) fac_tab[c] = 8'd1;
      end else if (rng < 128) fac_tab[c] = 8'd1;
      else if (rng < 256) fac_tab[c] = 8'd2;
      else if (rng < 512) fac_tab[c] = 8'd4;
      else if (rng < 1024) fac_tab[c] = 8'd8;
      else fac_tab[c] = 8'd16;
      return r;
    end
    if (s.smp < lo_tab[c]) begin
      if (shadow_cfg.rel_mask[c] && sent_tab[c] != 0) begin
        sent_tab[c] = '0;
        r.status = ST_SENT;
      end else r.status = ST_BELOW;
      return r;
    end
    if (s.smp > hi_tab[c]) return r;
    x = shadow_cfg.invert[c] ? SMP_MAX - s.smp : s.smp;
    d16 = {6'd0, x} - {6'd0, lo_tab[c]};
    d8 = (fac_tab[c] == 0) ? d16[7:0] : 8'(d16 / fac_tab[c]);
    fr = {1'b0, shadow_cfg.scale_from[7*c +: 7]};
    tt = {1'b0, shadow_cfg.scale_to[7*c +: 7]};
    if (tt < fr) return r;
    prod = d8 * (tt - fr);
    y = fr + 8'(prod >> 7);
    if (y < fr || y > tt || y == sent_tab[c]) return r;
    sent_tab[c] = y;
    r.status = ST_SENT;
    r.value = y[6:0];
    return r;
  endfunction

  // Driver: pop pending samples, random gap after each offer.
  int gap_left = 0;
  always @(posedge clk) begin
    sample_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // hold until the transfer happens
    end else begin
      if (in_valid) expected_verdicts.push_back(condition_sample(
          '{ch: in_sensor_index, smp: in_sample, pedal: in_pedal_up}));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (!gate_send && pending_samples.size() > 0) begin
        s = pending_samples.pop_front();
        in_valid <= 1'b1;
        in_sensor_index <= s.ch; in_sample <= s.smp; in_pedal_up <= s.pedal;
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random stall per result, check each transfer against the oldest.
  int stall_left = 0;
  always @(posedge clk) begin
    verdict_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result status=%0d value=%0d", $time,
                   out_status, out_value);
          errors++;
        end else begin
          e = expected_verdicts.pop_front();
          if (out_status !== e.status || out_value !== e.value) begin
            $display("%0t: mismatch expected status=%0d value=%0d, actual status=%0d value=%0d",
                     $time, e.status, e.value, out_status, out_value);
            errors++;
          end
        end
        stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else if (hold_off) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [9:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 10'd0;
      1: return 10'd1023;
      2: return 10'($urandom_range(60, 70));
      3: return 10'($urandom_range(870, 890));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_samples.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);  // margin after the last result is taken
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ENABLE:   shadow_cfg.enable = val[7:0];
      REG_RELEASE:  shadow_cfg.rel_mask = val[7:0];
      REG_INVERT:   shadow_cfg.invert = val[7:0];
      REG_PEDAL:    shadow_cfg.pedal_gate = val[7:0];
      REG_AUTOSENS: shadow_cfg.autosense = val[15:0];
      REG_SLOWDOWN: shadow_cfg.slowdown = val;
      REG_FROM:     shadow_cfg.scale_from = val[55:0];
      REG_TO:       shadow_cfg.scale_to = val[55:0];
      default: ;
    endcase
  endtask

  function automatic logic [55:0] rand_scale();
    logic [55:0] v;
    for (int i = 0; i < 8; i++) v[7*i +: 7] = 7'($urandom_range(0, 127));
    return v;
  endfunction

  task automatic push_random(int cnt);
    for (int i = 0; i < cnt; i++)
      pending_samples.push_back('{ch: 3'($urandom_range(0, 7)), smp: rand_sample(),
                                  pedal: 1'($urandom_range(0, 1))});
  endtask

  initial begin
    shadow_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, release send, abort, below minimum, scale overflow.
    write_reg(REG_ENABLE, 64'hFF);
    foreach (pending_samples[i]) ;
    pending_samples.push_back('{3'd0, 10'd500, 1'b0});
    pending_samples.push_back('{3'd0, 10'd0, 1'b0});     // release send
    pending_samples.push_back('{3'd0, 10'd0, 1'b0});     // below, no send
    pending_samples.push_back('{3'd1, 10'd1023, 1'b1});  // above maximum
    pending_samples.push_back('{3'd2, 10'd880, 1'b0});
    pending_samples.push_back('{3'd2, 10'd880, 1'b0});   // above the scale range, aborted again
    pending_samples.push_back('{3'd7, 10'd64, 1'b1});
    wait_idle();

    // Calibration: min, max, recalc; min above max; invert wrap; empty range.
    write_reg(REG_AUTOSENS, 16'b11_10_01_10_01_11_10_01);
    pending_samples.push_back('{3'd0, 10'd1000, 1'b0});  // min above max
    pending_samples.push_back('{3'd1, 10'd1023, 1'b1});
    pending_samples.push_back('{3'd2, 10'd0, 1'b0});
    pending_samples.push_back('{3'd3, 10'd100, 1'b0});
    pending_samples.push_back('{3'd4, 10'd700, 1'b0});
    pending_samples.push_back('{3'd7, 10'd5, 1'b1});
    wait_idle();
    write_reg(REG_AUTOSENS, 16'd0);
    write_reg(REG_INVERT, 64'hFF);
    write_reg(REG_FROM, {8{7'd127}});
    write_reg(REG_TO, {8{7'd0}});
    pending_samples.push_back('{3'd3, 10'd500, 1'b0});   // to below from
    wait_idle();
    write_reg(REG_FROM, 56'd0);
    write_reg(REG_TO, SCALE_TO_RST);
    pending_samples.push_back('{3'd3, 10'd1000, 1'b0});  // above maximum before inversion
    pending_samples.push_back('{3'd1, 10'd1023, 1'b0});
    wait_idle();

    // Random phases over a spread of settings.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_ENABLE, ph == 0 ? 64'hFF : 64'($urandom_range(0, 255)) | 64'h0F);
      write_reg(REG_RELEASE, ph == 1 ? 64'h0 : 64'($urandom_range(0, 255)));
      write_reg(REG_INVERT, ph == 2 ? 64'hFF : 64'($urandom_range(0, 255)));
      write_reg(REG_PEDAL, ph == 3 ? 64'hFF : 64'($urandom_range(0, 255)));
      write_reg(REG_AUTOSENS, ph % 3 == 0 ? 64'($urandom_range(0, 65535)) : 64'd0);
      write_reg(REG_SLOWDOWN, ph == 4 ? 64'hFFFF_FFFF_FFFF_FFFF :
                ph % 2 ? {$urandom_range(0, 3), $urandom_range(0, 3)} & 64'h0303_0303_0303_0303
                       : 64'd0);
      write_reg(REG_FROM, ph == 5 ? 56'd0 : rand_scale());
      write_reg(REG_TO, ph == 5 ? SCALE_TO_RST : rand_scale() | {8{7'h40}});
      push_random(125);
      if (ph == 6) begin
        // Long receiver hold while the sender keeps offering.
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      if (ph == 7) begin
        // Sender pauses until every result has drained.
        while (pending_samples.size() > 60) @(posedge clk);
        gate_send = 1'b1;
        while (in_valid || expected_verdicts.size() > 0) @(posedge clk);
        gate_send = 1'b0;
      end
      wait_idle();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_verdicts.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
src/scs_pkg.sv
src/scs_front.sv
src/scs_fifo.sv
src/scs_div.sv
src/scs_back.sv
src/sensor_calibrate_scale_conditioner.sv
tb/tb_top.sv
